@@ src/neg_pkg.sv @@
// shared constants, register map and config struct for the note envelope generator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package neg_pkg;

    localparam int LEVEL_W        = 25;
    localparam int FRAC_BITS      = 24;
    localparam int LEN_W          = 20;
    localparam int INDEX_BITS_DEF = 20;

    localparam logic [LEVEL_W-1:0] LEVEL_ONE = LEVEL_W'(64'd1 << FRAC_BITS);

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    localparam logic [REG_IDX_W-1:0] REG_ATTACK_LEN   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_ATTACK_STEP  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_KNEE_LEN     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_DECAY_START  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_DECAY_MUL    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_ENV_LEN      = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_RELEASE_LEN  = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_RELEASE_STEP = 3'd7;

    localparam logic [LEN_W-1:0]   RST_ATTACK_LEN   = 20'd1;
    localparam logic [LEVEL_W-1:0] RST_ATTACK_STEP  = LEVEL_ONE;
    localparam logic [LEN_W-1:0]   RST_KNEE_LEN     = 20'd0;
    localparam logic [LEVEL_W-1:0] RST_DECAY_START  = LEVEL_ONE;
    localparam logic [LEVEL_W-1:0] RST_DECAY_MUL    = LEVEL_ONE;
    localparam logic [LEN_W-1:0]   RST_ENV_LEN      = 20'd2;
    localparam logic [LEN_W-1:0]   RST_RELEASE_LEN  = 20'd0;
    localparam logic [LEVEL_W-1:0] RST_RELEASE_STEP = 25'd0;

    typedef struct packed {
        logic [LEN_W-1:0]   attack_len;
        logic [LEVEL_W-1:0] attack_step;
        logic [LEN_W-1:0]   knee_len;
        logic [LEVEL_W-1:0] decay_start;
        logic [LEVEL_W-1:0] decay_mul;
        logic [LEN_W-1:0]   env_len;
        logic [LEN_W-1:0]   release_len;
        logic [LEVEL_W-1:0] release_step;
    } t_cfg;

endpackage

`default_nettype wire

@@ src/neg_cfg_regs.sv @@
// apb register file holding the envelope shape registers
// depends on neg_pkg
`timescale 1ns / 1ps
`default_nettype none

module neg_cfg_regs (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [neg_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [neg_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [neg_pkg::APB_DATA_W-1:0] prdata,
    output logic                                pready,
    output neg_pkg::t_cfg                       o_cfg
);
    import neg_pkg::*;

    t_cfg                 r_cfg;
    logic [REG_IDX_W-1:0] w_idx;
    logic                 w_wr;

    assign w_idx  = paddr[APB_ADDR_W-1:2];
    assign w_wr   = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.attack_len   <= RST_ATTACK_LEN;
            r_cfg.attack_step  <= RST_ATTACK_STEP;
            r_cfg.knee_len     <= RST_KNEE_LEN;
            r_cfg.decay_start  <= RST_DECAY_START;
            r_cfg.decay_mul    <= RST_DECAY_MUL;
            r_cfg.env_len      <= RST_ENV_LEN;
            r_cfg.release_len  <= RST_RELEASE_LEN;
            r_cfg.release_step <= RST_RELEASE_STEP;
        end else if (w_wr) begin
            case (w_idx)
                REG_ATTACK_LEN:   r_cfg.attack_len   <= pwdata[LEN_W-1:0];
                REG_ATTACK_STEP:  r_cfg.attack_step  <= pwdata[LEVEL_W-1:0];
                REG_KNEE_LEN:     r_cfg.knee_len     <= pwdata[LEN_W-1:0];
                REG_DECAY_START:  r_cfg.decay_start  <= pwdata[LEVEL_W-1:0];
                REG_DECAY_MUL:    r_cfg.decay_mul    <= pwdata[LEVEL_W-1:0];
                REG_ENV_LEN:      r_cfg.env_len      <= pwdata[LEN_W-1:0];
                REG_RELEASE_LEN:  r_cfg.release_len  <= pwdata[LEN_W-1:0];
                REG_RELEASE_STEP: r_cfg.release_step <= pwdata[LEVEL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_ATTACK_LEN:   prdata = APB_DATA_W'(r_cfg.attack_len);
            REG_ATTACK_STEP:  prdata = APB_DATA_W'(r_cfg.attack_step);
            REG_KNEE_LEN:     prdata = APB_DATA_W'(r_cfg.knee_len);
            REG_DECAY_START:  prdata = APB_DATA_W'(r_cfg.decay_start);
            REG_DECAY_MUL:    prdata = APB_DATA_W'(r_cfg.decay_mul);
            REG_ENV_LEN:      prdata = APB_DATA_W'(r_cfg.env_len);
            REG_RELEASE_LEN:  prdata = APB_DATA_W'(r_cfg.release_len);
            REG_RELEASE_STEP: prdata = APB_DATA_W'(r_cfg.release_step);
            default:          prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

@@ src/neg_serial_mul.sv @@
// bit-serial shift-add multiplier, one multiplier bit per cycle
// depends on no package; widths come from parameters
`timescale 1ns / 1ps
`default_nettype none

module neg_serial_mul #(
    parameter int A_W = 25,
    parameter int B_W = 25
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [A_W-1:0]   i_a,
    input  wire logic [B_W-1:0]   i_b,
    output logic                  o_busy,
    output logic [A_W+B_W-1:0]    o_prod
);
    localparam int P_W   = A_W + B_W;
    localparam int CNT_W = $clog2(B_W + 1);

    logic [CNT_W-1:0] r_cnt;
    logic [A_W-1:0]   r_a;
    logic [P_W-1:0]   r_prod;
    logic [A_W:0]     w_sum;

    // upper half accumulates, multiplier bits shift out of the lower half
    assign w_sum  = {1'b0, r_prod[P_W-1:B_W]} + (r_prod[0] ? {1'b0, r_a} : '0);
    assign o_busy = (r_cnt != '0);
    assign o_prod = r_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(B_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a    <= i_a;
            r_prod <= {{A_W{1'b0}}, i_b};
        end else if (r_cnt != '0) begin
            r_prod <= {w_sum, r_prod[B_W-1:1]};
        end
    end

endmodule

`default_nettype wire

@@ src/note_envelope_generator_core.sv @@
// note envelope generator top level: stream ports, sequencer and output register
// depends on neg_pkg, neg_cfg_regs and neg_serial_mul
// Each input transfer yields one envelope level. An item runs through the setup state, one pass
// of the bit-serial multipliers (B_W = max(INDEX_BITS, 25) bits wide), a second pass of the
// envelope multiplier when the sample lies in the release ramp, and the output register;
// once the envelope is finished it skips the multipliers and goes straight to the output
// register. s_axis_tready returns in the same cycle that the result enters the output
// register. A result waiting in the output register does not hold up the multiplier passes
// of the next item, which then waits in S_OUT until the output register is free.
`timescale 1ns / 1ps
`default_nettype none

module note_envelope_generator_core #(
    parameter int INDEX_BITS = neg_pkg::INDEX_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [neg_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [neg_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [neg_pkg::APB_DATA_W-1:0] prdata,
    output logic                                pready,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [7:0]                     s_axis_tdata,   // [0] start_req
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output logic      [31:0]                    m_axis_tdata,   // [24:0] level
    output logic      [0:0]                     m_axis_tuser    // [0] finished
);
    import neg_pkg::*;

    localparam int CMP_W = (INDEX_BITS > LEN_W) ? INDEX_BITS : LEN_W;
    localparam int B_W   = (INDEX_BITS > LEVEL_W) ? INDEX_BITS : LEVEL_W;
    localparam int P_W   = LEVEL_W + B_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SETUP = 3'd1;
    localparam logic [2:0] S_MUL1  = 3'd2;
    localparam logic [2:0] S_MUL2  = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    localparam logic [1:0] K_ATTACK = 2'd0;
    localparam logic [1:0] K_KNEE   = 2'd1;
    localparam logic [1:0] K_DECAY  = 2'd2;
    localparam logic [1:0] K_FIRST  = 2'd3;

    t_cfg w_cfg;

    logic [2:0]            r_state;
    logic [INDEX_BITS-1:0] r_idx;
    logic [LEVEL_W-1:0]    r_env;
    logic                  r_dec;
    logic [1:0]            r_kind;
    logic                  r_rel_on;
    logic [LEVEL_W-1:0]    r_level;
    logic                  r_fin;
    logic                  r_ovalid;
    logic [LEVEL_W-1:0]    r_olevel;
    logic                  r_ofin;

    logic [CMP_W-1:0]   w_idx_c;
    logic [CMP_W-1:0]   w_env_len_c;
    logic [CMP_W-1:0]   w_rel_len_c;
    logic [CMP_W-1:0]   w_rel_start;
    logic [CMP_W-1:0]   w_diff;
    logic               w_fin;
    logic               w_rel_on;
    logic [1:0]         w_kind;
    logic [LEVEL_W-1:0] w_decay_mul;
    logic [LEVEL_W-1:0] w_decay_start;
    logic [LEVEL_W-1:0] w_env_new;
    logic [LEVEL_W-1:0] w_r;
    logic               w_in_xfer;
    logic               w_out_free;

    logic               w_a_start;
    logic [LEVEL_W-1:0] w_a_a;
    logic [B_W-1:0]     w_a_b;
    logic               w_a_busy;
    logic [P_W-1:0]     w_a_prod;
    logic               w_b_start;
    logic               w_b_busy;
    logic [P_W-1:0]     w_b_prod;

    neg_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign w_idx_c     = CMP_W'(r_idx);
    assign w_env_len_c = CMP_W'(w_cfg.env_len);
    assign w_rel_len_c = CMP_W'(w_cfg.release_len);
    assign w_fin       = (w_idx_c >= w_env_len_c);
    assign w_rel_start = (w_rel_len_c < w_env_len_c) ? (w_env_len_c - w_rel_len_c) : '0;
    assign w_rel_on    = (w_cfg.release_len != '0) && (w_idx_c >= w_rel_start);
    assign w_diff      = w_idx_c - w_rel_start;

    assign w_decay_mul   = (w_cfg.decay_mul > LEVEL_ONE) ? LEVEL_ONE : w_cfg.decay_mul;
    assign w_decay_start = (w_cfg.decay_start > LEVEL_ONE) ? LEVEL_ONE : w_cfg.decay_start;

    always_comb begin
        if (w_idx_c < CMP_W'(w_cfg.attack_len)) begin
            w_kind = K_ATTACK;
        end else if ((w_cfg.knee_len != '0) && (w_idx_c < CMP_W'(w_cfg.knee_len))) begin
            w_kind = K_KNEE;
        end else if (r_dec) begin
            w_kind = K_DECAY;
        end else begin
            w_kind = K_FIRST;
        end
    end

    always_comb begin
        case (r_kind)
            K_ATTACK: w_env_new = (w_a_prod > P_W'(LEVEL_ONE)) ? LEVEL_ONE
                                                               : w_a_prod[LEVEL_W-1:0];
            K_KNEE:   w_env_new = LEVEL_ONE;
            K_DECAY:  w_env_new = w_a_prod[FRAC_BITS +: LEVEL_W];
            K_FIRST:  w_env_new = w_decay_start;
            default:  w_env_new = '0;
        endcase
    end

    // release scale, floored at zero
    assign w_r = (w_b_prod < P_W'(LEVEL_ONE)) ? (LEVEL_ONE - w_b_prod[LEVEL_W-1:0]) : '0;

    assign w_a_start = ((r_state == S_SETUP) && !w_fin)
                    || ((r_state == S_MUL1) && !w_a_busy && r_rel_on);
    assign w_a_a     = (r_state == S_SETUP)
                     ? ((w_kind == K_ATTACK) ? w_cfg.attack_step : w_decay_mul)
                     : w_env_new;
    assign w_a_b     = (r_state == S_SETUP)
                     ? ((w_kind == K_ATTACK) ? B_W'(r_idx) : B_W'(r_env))
                     : B_W'(w_r);
    assign w_b_start = (r_state == S_SETUP) && !w_fin;

    neg_serial_mul #(
        .A_W (LEVEL_W),
        .B_W (B_W)
    ) u_mul_env (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_a_start),
        .i_a     (w_a_a),
        .i_b     (w_a_b),
        .o_busy  (w_a_busy),
        .o_prod  (w_a_prod)
    );

    neg_serial_mul #(
        .A_W (LEVEL_W),
        .B_W (B_W)
    ) u_mul_rel (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_b_start),
        .i_a     (w_cfg.release_step),
        .i_b     (B_W'(w_diff)),
        .o_busy  (w_b_busy),
        .o_prod  (w_b_prod)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_xfer     = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_ovalid || m_axis_tready;

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = 32'(r_olevel);
    assign m_axis_tuser  = r_ofin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_idx    <= '0;
            r_env    <= '0;
            r_dec    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready && !((r_state == S_OUT) && w_out_free)) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_xfer) begin
                        if (s_axis_tdata[0]) begin
                            r_idx <= '0;
                            r_env <= '0;
                            r_dec <= 1'b0;
                        end
                        r_state <= S_SETUP;
                    end
                end
                S_SETUP: begin
                    if (w_fin) begin
                        r_env   <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_MUL1;
                    end
                end
                S_MUL1: begin
                    if (!w_a_busy && !w_b_busy) begin
                        r_env <= w_env_new;
                        if (r_kind == K_FIRST) begin
                            r_dec <= 1'b1;
                        end
                        r_state <= r_rel_on ? S_MUL2 : S_OUT;
                    end
                end
                S_MUL2: begin
                    if (!w_a_busy) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_ovalid <= 1'b1;
                        if (!(&r_idx)) begin
                            r_idx <= r_idx + 1'b1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_SETUP: begin
                r_kind   <= w_kind;
                r_rel_on <= w_rel_on;
                r_fin    <= w_fin;
                r_level  <= '0;
            end
            S_MUL1: begin
                if (!w_a_busy) begin
                    r_level <= w_env_new;
                end
            end
            S_MUL2: begin
                if (!w_a_busy) begin
                    r_level <= w_a_prod[FRAC_BITS +: LEVEL_W];
                end
            end
            S_OUT: begin
                if (w_out_free) begin
                    r_olevel <= r_level;
                    r_ofin   <= r_fin;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

@@ src/neg_checker.sv @@
// port-level checks for note_envelope_generator_core, attached by bind
// depends on neg_pkg
`timescale 1ns / 1ps
`default_nettype none

module neg_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata,
    input wire logic [0:0]  m_axis_tuser
);
    import neg_pkg::*;

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // one item in work at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while an item is in work");

    a_fin_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[LEVEL_W-1:0] == '0)
        else $error("finished transfer with nonzero level");

    a_level_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[LEVEL_W-1:0] <= LEVEL_ONE
            && m_axis_tdata[31:LEVEL_W] == '0)
        else $error("level above full scale");

endmodule

bind note_envelope_generator_core neg_checker u_neg_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
